// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`ASSERT_PROP(lbl, clk, rst_n, !(cond))

`endif

// File: hdl/isj_pkg.sv
`timescale 1ns / 1ps
package isj_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BITS    = 11;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int KEY_W       = 3 * KEY_BITS;
	localparam int IN_KEY_W    = 11;
	localparam int FIRST_W     = 16;
	localparam int SECOND_W    = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [FIRST_W-1:0] PROBE_MAX = {FIRST_W{1'b1}};

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_PROBE = 2'd2,
		OP_DRAIN = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_PAIR     = 2'd0,
		KIND_FIRST    = 2'd1,
		KIND_SECOND   = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
	} cmd_t;

	// Keep the low KEY_BITS of each component, h in the top slice.
	function automatic logic [KEY_W-1:0] pack_key(
		input logic [IN_KEY_W-1:0] h,
		input logic [IN_KEY_W-1:0] k,
		input logic [IN_KEY_W-1:0] l
	);
		logic [KEY_BITS-1:0] hh;
		logic [KEY_BITS-1:0] kk;
		logic [KEY_BITS-1:0] ll;
		hh = KEY_BITS'(h);
		kk = KEY_BITS'(k);
		ll = KEY_BITS'(l);
		return {hh, kk, ll};
	endfunction

endpackage

// File: hdl/isj_front.sv
`timescale 1ns / 1ps
module isj_front
	import isj_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [1:0]                 opcode,
	input  logic signed [IN_KEY_W-1:0] key_h,
	input  logic signed [IN_KEY_W-1:0] key_k,
	input  logic signed [IN_KEY_W-1:0] key_l,
	output logic                       push,
	output cmd_t                       push_cmd,
	input  logic                       q_full
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;

	assign item_stall = valid_s1 && q_full;
	assign accept     = item_valid && !item_stall;
	assign push       = valid_s1 && !q_full;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Decode the opcode and pack the key once, at the front.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op  <= op_t'(opcode);
			cmd_s1.key <= pack_key(key_h, key_k, key_l);
		end
	end

endmodule

// File: hdl/isj_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module isj_queue
	import isj_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output cmd_t q_cmd
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	`ASSERT_NEVER(a_q_no_overflow, clk, arst_n, push && full)
	`ASSERT_NEVER(a_q_no_underflow, clk, arst_n, pop && !q_valid)
	`ASSERT_PROP(a_q_count_up, clk, arst_n, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))

endmodule

// File: hdl/isj_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module isj_back
	import isj_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  cmd_t                q_cmd,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [1:0]          kind,
	output logic [FIRST_W-1:0]  first_index,
	output logic [SECOND_W-1:0] second_index,
	output logic                last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		kind_t               kind;
		logic [FIRST_W-1:0]  first;
		logic [SECOND_W-1:0] second;
		logic                last;
	} res_t;

	logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
	logic             flag_mem [TABLE_DEPTH];

	state_t             state_q;
	logic [CNT_W-1:0]   stored_cnt_q;
	logic [FIRST_W-1:0] probe_cnt_q;
	logic [CNT_W-1:0]   cursor_q;
	logic [KEY_W-1:0]   key_q;
	logic [FIRST_W-1:0] first_q;
	logic [ADDR_W-1:0]  scan_addr_q;
	logic               issue_done_q;
	logic               rd_vld_s1;
	logic [ADDR_W-1:0]  rd_pos_s1;
	logic [KEY_W-1:0]   rd_key_s1;
	logic               flag_rd_s1;
	logic [ADDR_W-1:0]  drain_pos_q;
	logic               out_valid_q;
	res_t               out_q;

	logic              slot_free;
	logic              room;
	logic              hit;
	logic              miss_end;
	logic              issue;
	logic              load_wr;
	logic              drain_rd;
	logic              flag_we;
	logic [ADDR_W-1:0] flag_wa;
	logic              out_load;
	res_t              res_d;

	assign slot_free = !out_valid_q || !result_stall;
	assign pop       = (state_q == ST_IDLE) && q_valid && slot_free;
	assign room      = (stored_cnt_q < CNT_W'(TABLE_DEPTH));
	assign hit       = (state_q == ST_SCAN) && rd_vld_s1 && (rd_key_s1 == key_q);
	assign miss_end  = (state_q == ST_SCAN) && rd_vld_s1 && !hit && (rd_pos_s1 == '0);
	assign issue     = (state_q == ST_SCAN) && !issue_done_q && !hit;
	assign load_wr   = pop && (q_cmd.op == OP_LOAD) && room;
	assign drain_rd  = pop && (q_cmd.op == OP_DRAIN) && (cursor_q < stored_cnt_q);

	// A load clears the flag of its new position, so no clearing pass is needed.
	assign flag_we = load_wr || hit;
	assign flag_wa = hit ? rd_pos_s1 : stored_cnt_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (load_wr) begin
			key_mem[stored_cnt_q[ADDR_W-1:0]] <= q_cmd.key;
		end
		if (issue) begin
			rd_key_s1 <= key_mem[scan_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[flag_wa] <= hit;
		end
		if (drain_rd) begin
			flag_rd_s1 <= flag_mem[cursor_q[ADDR_W-1:0]];
		end
	end

	always_comb begin
		out_load = 1'b0;
		res_d    = '{kind: KIND_PAIR, first: '0, second: '0, last: 1'b0};
		if (pop && (q_cmd.op == OP_LOAD) && !room) begin
			out_load   = 1'b1;
			res_d.kind = KIND_OVERFLOW;
		end
		if (pop && (q_cmd.op == OP_PROBE) && (stored_cnt_q == '0)) begin
			out_load    = 1'b1;
			res_d.kind  = KIND_FIRST;
			res_d.first = probe_cnt_q;
		end
		if (hit) begin
			out_load     = 1'b1;
			res_d.kind   = KIND_PAIR;
			res_d.first  = first_q;
			res_d.second = SECOND_W'(rd_pos_s1);
		end
		if (miss_end) begin
			out_load    = 1'b1;
			res_d.kind  = KIND_FIRST;
			res_d.first = first_q;
		end
		if ((state_q == ST_DRAIN) && !flag_rd_s1) begin
			out_load     = 1'b1;
			res_d.kind   = KIND_SECOND;
			res_d.second = SECOND_W'(drain_pos_q);
			res_d.last   = ((CNT_W'(drain_pos_q) + CNT_W'(1)) == stored_cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			stored_cnt_q <= '0;
			probe_cnt_q  <= '0;
			cursor_q     <= '0;
			key_q        <= '0;
			first_q      <= '0;
			scan_addr_q  <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_pos_s1    <= '0;
			drain_pos_q  <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q       <= res_d;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= issue;
			rd_pos_s1 <= scan_addr_q;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (q_cmd.op)
							OP_CLEAR: begin
								stored_cnt_q <= '0;
								probe_cnt_q  <= '0;
								cursor_q     <= '0;
							end
							OP_LOAD: begin
								if (room) begin
									stored_cnt_q <= stored_cnt_q + 1'b1;
								end
							end
							OP_PROBE: begin
								key_q   <= q_cmd.key;
								first_q <= probe_cnt_q;
								if (probe_cnt_q != PROBE_MAX) begin
									probe_cnt_q <= probe_cnt_q + 1'b1;
								end
								if (stored_cnt_q != '0) begin
									// Scan down from the newest entry so the last duplicate wins.
									scan_addr_q  <= ADDR_W'(stored_cnt_q - 1'b1);
									issue_done_q <= 1'b0;
									state_q      <= ST_SCAN;
								end
							end
							OP_DRAIN: begin
								if (drain_rd) begin
									drain_pos_q <= cursor_q[ADDR_W-1:0];
									cursor_q    <= cursor_q + 1'b1;
									state_q     <= ST_DRAIN;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						if (scan_addr_q == '0) begin
							issue_done_q <= 1'b1;
						end else begin
							scan_addr_q <= scan_addr_q - 1'b1;
						end
					end
					if (hit || miss_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = out_q.kind;
	assign first_index  = out_q.first;
	assign second_index = out_q.second;
	assign last         = out_q.last;

	`ASSERT_PROP(a_out_slot_free, clk, arst_n, out_load |-> (!out_valid_q || !result_stall))
	`ASSERT_PROP(a_cursor_bound, clk, arst_n, cursor_q <= stored_cnt_q)
	`ASSERT_PROP(a_scan_in_range, clk, arst_n, (state_q == ST_SCAN) |-> (CNT_W'(scan_addr_q) < stored_cnt_q))

endmodule

// File: hdl/index_set_join_top.sv
`timescale 1ns / 1ps
// Joins a loaded list of three-part keys against a stream of probe keys. The front
// stage registers and decodes each transfer and hands it to a four-entry command
// queue, so new items are taken while the back end is busy or a result waits. The
// back end works on one command at a time: clear and load complete in ST_IDLE, a
// drain passes through ST_DRAIN unless the cursor is already past the end, and a
// probe scans the key memory from the newest entry down through its single read
// port, one entry per cycle, and stops early on the first match. Matched flags need
// no clearing pass after reset or clear: each load resets the flag of the
// position it writes, and only loaded positions are ever read.
module index_set_join_top
	import isj_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [1:0]                 opcode,
	input  logic signed [IN_KEY_W-1:0] key_h,
	input  logic signed [IN_KEY_W-1:0] key_k,
	input  logic signed [IN_KEY_W-1:0] key_l,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [1:0]                 kind,
	output logic [FIRST_W-1:0]         first_index,
	output logic [SECOND_W-1:0]        second_index,
	output logic                       last
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	logic q_valid;
	cmd_t q_cmd;

	isj_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.opcode     (opcode),
		.key_h      (key_h),
		.key_k      (key_k),
		.key_l      (key_l),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_full     (q_full)
	);

	isj_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd)
	);

	isj_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.first_index  (first_index),
		.second_index (second_index),
		.last         (last)
	);

endmodule

// File: sim/index_set_join_top_test.sv
`timescale 1ns / 1ps
module index_set_join_top_test;
	import isj_pkg::*;

	localparam int RANDOM_ITEMS    = 556;
	localparam int HOLD_AFTER      = 60;
	localparam int LONG_HOLD       = 400;
	localparam int SETTLE_CYCLES   = 64;
	localparam int SESSION_CAP     = 100;

	localparam logic signed [IN_KEY_W-1:0] KEY_MIN = 11'h400;
	localparam logic signed [IN_KEY_W-1:0] KEY_MAX = 11'h3FF;
	localparam logic signed [IN_KEY_W-1:0] CORNERS [5] =
		'{11'h400, 11'h7FF, 11'h000, 11'h001, 11'h3FF};

	typedef struct packed {
		logic signed [IN_KEY_W-1:0] h;
		logic signed [IN_KEY_W-1:0] k;
		logic signed [IN_KEY_W-1:0] l;
	} key3_t;

	typedef struct {
		kind_t                kind;
		logic [FIRST_W-1:0]   first_index;
		logic [SECOND_W-1:0]  second_index;
		logic                 last;
	} join_result_t;

	class join_scoreboard;
		logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
		bit               hit_flags [TABLE_DEPTH];
		int               fill_count;
		int               probe_seq;
		int               drain_pos;
		int               errors;
		join_result_t     results_due [$];

		function void apply_item(op_t op, key3_t kv);
			logic [KEY_W-1:0] match_key;
			join_result_t     r;
			int               pos;
			bit               found;
			match_key = {kv.h[KEY_BITS-1:0], kv.k[KEY_BITS-1:0], kv.l[KEY_BITS-1:0]};
			r.kind = KIND_PAIR;
			r.first_index = '0;
			r.second_index = '0;
			r.last = 1'b0;
			case (op)
				OP_CLEAR: begin
					foreach (hit_flags[i]) hit_flags[i] = 1'b0;
					fill_count = 0;
					probe_seq = 0;
					drain_pos = 0;
				end
				OP_LOAD: begin
					if (fill_count >= TABLE_DEPTH) begin
						r.kind = KIND_OVERFLOW;
						results_due.insert(results_due.size(), r);
					end else begin
						key_mem[fill_count] = match_key;
						fill_count++;
					end
				end
				OP_PROBE: begin
					r.first_index = FIRST_W'(probe_seq);
					if (probe_seq < int'(PROBE_MAX)) probe_seq++;
					found = 1'b0;
					// scan from the newest entry so the last duplicate wins
					for (pos = fill_count - 1; pos >= 0; pos--) begin
						if (key_mem[pos] == match_key) begin
							found = 1'b1;
							break;
						end
					end
					if (found) begin
						hit_flags[pos] = 1'b1;
						r.second_index = SECOND_W'(pos);
					end else begin
						r.kind = KIND_FIRST;
					end
					results_due.insert(results_due.size(), r);
				end
				OP_DRAIN: begin
					if (drain_pos < fill_count) begin
						pos = drain_pos;
						drain_pos++;
						if (!hit_flags[pos]) begin
							r.kind = KIND_SECOND;
							r.second_index = SECOND_W'(pos);
							r.last = (pos + 1 == fill_count);
							results_due.insert(results_due.size(), r);
						end
					end
				end
			endcase
		endfunction

		function void check_result(kind_t kind_seen, logic [FIRST_W-1:0] first_seen,
				logic [SECOND_W-1:0] second_seen, logic last_seen);
			join_result_t want;
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result: kind %0d first %0d second %0d last %0d",
					$time, kind_seen, first_seen, second_seen, last_seen);
				errors++;
				return;
			end
			want = results_due.pop_front();
			if (kind_seen !== want.kind) begin
				$display("%0t: kind mismatch: expected %0d, actual %0d",
					$time, want.kind, kind_seen);
				errors++;
			end
			if (first_seen !== want.first_index) begin
				$display("%0t: first_index mismatch: expected %0d, actual %0d",
					$time, want.first_index, first_seen);
				errors++;
			end
			if (second_seen !== want.second_index) begin
				$display("%0t: second_index mismatch: expected %0d, actual %0d",
					$time, want.second_index, second_seen);
				errors++;
			end
			if (last_seen !== want.last) begin
				$display("%0t: last mismatch: expected %0d, actual %0d",
					$time, want.last, last_seen);
				errors++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       item_valid = 1'b0;
	logic                       item_stall;
	logic [1:0]                 opcode = OP_CLEAR;
	logic signed [IN_KEY_W-1:0] key_h = '0;
	logic signed [IN_KEY_W-1:0] key_k = '0;
	logic signed [IN_KEY_W-1:0] key_l = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic [1:0]                 kind;
	logic [FIRST_W-1:0]         first_index;
	logic [SECOND_W-1:0]        second_index;
	logic                       last;

	join_scoreboard sb = new();

	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int send_calm = 0;
	int recv_calm = 0;

	index_set_join_top uut (.*);

	always #4 clk = ~clk;

	function automatic int draw_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	function automatic logic signed [IN_KEY_W-1:0] random_comp();
		if ($urandom_range(0, 3) == 0) return CORNERS[$urandom_range(0, 4)];
		return IN_KEY_W'($urandom);
	endfunction

	function automatic key3_t random_key();
		key3_t kv;
		kv.h = random_comp();
		kv.k = random_comp();
		kv.l = random_comp();
		return kv;
	endfunction

	function automatic key3_t key_of(logic signed [IN_KEY_W-1:0] h,
			logic signed [IN_KEY_W-1:0] k, logic signed [IN_KEY_W-1:0] l);
		key3_t kv;
		kv.h = h;
		kv.k = k;
		kv.l = l;
		return kv;
	endfunction

	task automatic send_item(input op_t op, input key3_t kv);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		key_h <= kv.h;
		key_k <= kv.k;
		key_l <= kv.l;
		do @(posedge clk); while (item_stall);
		sb.apply_item(op, kv);
	endtask

	// result side: random stalls, one long hold-off once the random phase is running
	initial begin : result_side
		int gap;
		forever begin
			if (hold_request && !hold_done) begin
				gap = LONG_HOLD;
				hold_done = 1'b1;
			end else begin
				gap = draw_gap(recv_calm);
			end
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!result_valid);
			sb.check_result(kind_t'(kind), first_index, second_index, last);
		end
	end

	initial begin : stimulus
		key3_t session_keys [$];
		key3_t kv;
		op_t   op;
		int    sent;
		int    n;
		int    b;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, duplicates, misses, drains over matched tail
		send_item(OP_CLEAR, key_of(KEY_MAX, KEY_MIN, KEY_MAX));
		send_item(OP_LOAD, key_of(KEY_MAX, KEY_MAX, KEY_MAX));
		send_item(OP_LOAD, key_of(KEY_MIN, KEY_MIN, KEY_MIN));
		send_item(OP_LOAD, key_of(11'sd0, 11'sd0, 11'sd0));
		send_item(OP_LOAD, key_of(11'sd5, -11'sd3, 11'sd7));
		send_item(OP_LOAD, key_of(KEY_MAX, KEY_MAX, KEY_MAX));
		send_item(OP_PROBE, key_of(KEY_MAX, KEY_MAX, KEY_MAX));
		send_item(OP_PROBE, key_of(KEY_MIN, KEY_MIN, KEY_MIN));
		send_item(OP_PROBE, key_of(11'sd1, 11'sd2, 11'sd3));
		send_item(OP_PROBE, key_of(KEY_MAX, KEY_MAX, 11'sd1022));
		send_item(OP_PROBE, key_of(KEY_MAX, KEY_MAX, KEY_MAX));
		send_item(OP_PROBE, key_of(11'sd5, -11'sd3, 11'sd7));
		repeat (6) send_item(OP_DRAIN, key_of(KEY_MIN, KEY_MAX, KEY_MIN));
		send_item(OP_LOAD, key_of(-11'sd1, 11'sd0, -11'sd1));
		send_item(OP_DRAIN, key_of(11'sd0, 11'sd0, 11'sd0));
		send_item(OP_DRAIN, key_of(11'sd0, 11'sd0, 11'sd0));
		send_item(OP_PROBE, key_of(-11'sd1, 11'sd0, -11'sd1));
		send_item(OP_CLEAR, key_of(11'sd0, 11'sd0, 11'sd0));
		send_item(OP_DRAIN, key_of(11'sd0, 11'sd0, 11'sd0));

		// random sessions: loads with reused keys, probes mostly on stored keys
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (session_keys.size() > SESSION_CAP || $urandom_range(0, 3) != 0) begin
				send_item(OP_CLEAR, random_key());
				session_keys.delete();
				sent++;
			end
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 60) : $urandom_range(0, 20);
			repeat (n) begin
				if (session_keys.size() > 0 && $urandom_range(0, 2) == 0)
					kv = session_keys[$urandom_range(0, session_keys.size() - 1)];
				else
					kv = random_key();
				send_item(OP_LOAD, kv);
				session_keys.insert(session_keys.size(), kv);
				sent++;
			end
			repeat ($urandom_range(0, n + 4)) begin
				b = $urandom_range(0, 9);
				if (session_keys.size() > 0 && b < 8) begin
					kv = session_keys[$urandom_range(0, session_keys.size() - 1)];
					// flip one bit for a near miss
					if (b == 7) begin
						b = $urandom_range(0, 3 * IN_KEY_W - 1);
						kv[b] = ~kv[b];
					end
				end else begin
					kv = random_key();
				end
				send_item(OP_PROBE, kv);
				sent++;
			end
			repeat ($urandom_range(0, session_keys.size() + 3)) begin
				send_item(OP_DRAIN, random_key());
				sent++;
			end
			repeat ($urandom_range(0, 3)) begin
				op = op_t'($urandom_range(0, 3));
				kv = random_key();
				send_item(op, kv);
				if (op == OP_CLEAR) session_keys.delete();
				if (op == OP_LOAD) session_keys.insert(session_keys.size(), kv);
				sent++;
			end
			if (sent >= HOLD_AFTER) hold_request = 1'b1;
		end
		item_valid <= 1'b0;

		while (sb.results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/isj_pkg.sv
hdl/isj_front.sv
hdl/isj_queue.sv
hdl/isj_back.sv
hdl/index_set_join_top.sv
sim/index_set_join_top_test.sv
